// ----- rtl/core/crt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_pkg
// Shared defaults, datapath commands and status for the range table unit.
// ----------------------------------------------------------------------------
package crt_pkg;

	localparam int MAX_RANGES_DEF = 16;
	localparam int PAGE_BYTES_DEF = 4096;
	localparam int ADDR_W         = 32;
	localparam int LEN_W          = 32;
	localparam int END_W          = 34;
	localparam int USED_W         = 5;
	localparam int OUT_W          = 8;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_SPAN,
		DP_READ,
		DP_NEXT,
		DP_GRAB,
		DP_APPEND,
		DP_FULL,
		DP_HIT,
		DP_RESERVE,
		DP_ABSORB,
		DP_KEEP,
		DP_FINAL
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic is_query;
		logic at_end;
		logic full;
		logic touch;
		logic covers;
		logic hit;
		logic is_cur;
	} dp_status_t;

endpackage

// ----- rtl/core/crt_remdiv.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_remdiv
// Page remainder unit: two lanes, a mod PAGE_BYTES and b mod PAGE_BYTES, by
// reciprocal multiplication in a pipeline of input, product, estimate and remainder registers.
// ----------------------------------------------------------------------------
module crt_remdiv #(
	parameter int PAGE_BYTES = crt_pkg::PAGE_BYTES_DEF,
	parameter int RW         = $clog2(PAGE_BYTES + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [crt_pkg::ADDR_W-1:0] a,
	input  logic [crt_pkg::ADDR_W-1:0] b,
	output logic                       done,
	output logic [RW-1:0]              rem_a,
	output logic [RW-1:0]              rem_b
);

	localparam int LG = $clog2(PAGE_BYTES);
	localparam int SH = crt_pkg::ADDR_W + LG;
	localparam int MW = crt_pkg::ADDR_W + 1;
	localparam int PW = crt_pkg::ADDR_W + MW;
	// floor(2^SH / PAGE_BYTES): the quotient estimate is exact or one low
	localparam logic [MW-1:0] RECIP = MW'((64'd1 << SH) / 64'(PAGE_BYTES));
	localparam logic [crt_pkg::ADDR_W-1:0] PAGE_A = crt_pkg::ADDR_W'(PAGE_BYTES);
	localparam logic [RW:0] PAGE_V = (RW + 1)'(PAGE_BYTES);

	logic [3:0]                 stage_q;
	logic [crt_pkg::ADDR_W-1:0] sa_q;
	logic [crt_pkg::ADDR_W-1:0] sb_q;
	logic [PW-1:0]              pa_s1;
	logic [PW-1:0]              pb_s1;
	logic [RW:0]                ea_s2;
	logic [RW:0]                eb_s2;
	logic [RW-1:0]              ra_s3;
	logic [RW-1:0]              rb_s3;
	logic [crt_pkg::ADDR_W-1:0] qa;
	logic [crt_pkg::ADDR_W-1:0] qb;
	logic [RW:0]                ea_next;
	logic [RW:0]                eb_next;
	logic [RW-1:0]              ra_next;
	logic [RW-1:0]              rb_next;

	always_comb begin
		qa      = crt_pkg::ADDR_W'(pa_s1 >> SH);
		qb      = crt_pkg::ADDR_W'(pb_s1 >> SH);
		ea_next = (RW + 1)'(sa_q - qa * PAGE_A);
		eb_next = (RW + 1)'(sb_q - qb * PAGE_A);
		// one correction step covers the low quotient estimate
		ra_next = (ea_s2 >= PAGE_V) ? RW'(ea_s2 - PAGE_V) : RW'(ea_s2);
		rb_next = (eb_s2 >= PAGE_V) ? RW'(eb_s2 - PAGE_V) : RW'(eb_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q <= '0;
		end else begin
			stage_q <= {stage_q[2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sa_q <= a;
			sb_q <= b;
		end
		pa_s1 <= PW'(sa_q) * PW'(RECIP);
		pb_s1 <= PW'(sb_q) * PW'(RECIP);
		ea_s2 <= ea_next;
		eb_s2 <= eb_next;
		ra_s3 <= ra_next;
		rb_s3 <= rb_next;
	end

	assign done  = stage_q[3];
	assign rem_a = ra_s3;
	assign rem_b = rb_s3;

endmodule

// ----- rtl/core/crt_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_datapath
// Range table memory, span registers, pointers and the compare logic that
// the controller steps through scan, join and write-back.
// ----------------------------------------------------------------------------
module crt_datapath #(
	parameter int MAX_RANGES = crt_pkg::MAX_RANGES_DEF,
	parameter int PAGE_BYTES = crt_pkg::PAGE_BYTES_DEF,
	parameter int CW         = $clog2(MAX_RANGES + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  crt_pkg::dp_cmd_t           cmd,
	input  logic                       in_cmd,
	input  logic [crt_pkg::ADDR_W-1:0] in_base,
	input  logic [crt_pkg::LEN_W-1:0]  in_len,
	output crt_pkg::dp_status_t        stat,
	output logic [CW-1:0]              count,
	output logic                       status_bit,
	output logic                       hit_bit
);

	localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int RW = $clog2(PAGE_BYTES + 1);
	localparam int EW = crt_pkg::END_W;
	localparam int LW = crt_pkg::LEN_W + 1;
	localparam logic [EW-1:0] PAGE_E = EW'(PAGE_BYTES);

	logic [crt_pkg::ADDR_W-1:0] mem_base [MAX_RANGES];
	logic [LW-1:0]              mem_len  [MAX_RANGES];

	logic                       query_q;
	logic                       status_q;
	logic                       hit_q;
	logic [CW-1:0]              count_q;
	logic [CW-1:0]              idx_q;
	logic [CW-1:0]              wr_q;
	logic [CW-1:0]              cur_idx_q;
	logic [CW-1:0]              cur_pos_q;
	logic [crt_pkg::ADDR_W-1:0] base_q;
	logic [crt_pkg::LEN_W-1:0]  len_q;
	logic [EW-1:0]              lo_q;
	logic [EW-1:0]              hi_q;
	logic [crt_pkg::ADDR_W-1:0] rd_base_s1;
	logic [LW-1:0]              rd_len_s1;

	logic                       div_start;
	logic                       div_done;
	logic [RW-1:0]              rem_a;
	logic [RW-1:0]              rem_b;

	logic [EW-1:0]              rd_lo;
	logic [EW-1:0]              rd_hi;
	logic [EW-1:0]              new_lo;
	logic [EW-1:0]              new_hi;
	logic [EW-1:0]              r_start;
	logic [EW-1:0]              r_pad;
	logic [EW-1:0]              r_end;
	logic                       wr_en;
	logic [CW-1:0]              wr_addr;
	logic [crt_pkg::ADDR_W-1:0] wr_base;
	logic [LW-1:0]              wr_len;

	assign div_start = (cmd == crt_pkg::DP_LOAD) && (in_cmd == crt_pkg::CMD_INSERT);

	crt_remdiv #(
		.PAGE_BYTES(PAGE_BYTES),
		.RW        (RW)
	) u_remdiv (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.a     (in_base),
		.b     (in_len),
		.done  (div_done),
		.rem_a (rem_a),
		.rem_b (rem_b)
	);

	always_comb begin
		rd_lo   = EW'(rd_base_s1);
		rd_hi   = EW'(rd_base_s1) + EW'(rd_len_s1);
		new_lo  = (rd_lo < lo_q) ? rd_lo : lo_q;
		new_hi  = (rd_hi > hi_q) ? rd_hi : hi_q;
		// round start down and size up to whole pages
		r_start = EW'(base_q) - EW'(rem_a);
		r_pad   = (rem_b == '0) ? '0 : (PAGE_E - EW'(rem_b));
		r_end   = r_start + EW'(len_q) + r_pad;
	end

	always_comb begin
		stat.div_done = div_done;
		stat.is_query = query_q;
		stat.at_end   = (idx_q >= count_q);
		stat.full     = (count_q >= CW'(MAX_RANGES));
		stat.touch    = !((hi_q < rd_lo) || (lo_q > rd_hi));
		stat.covers   = (lo_q >= rd_lo) && (hi_q <= rd_hi);
		stat.hit      = ((lo_q >= rd_lo) && (lo_q < rd_hi)) ||
		                ((hi_q >= rd_lo) && (hi_q < rd_hi));
		stat.is_cur   = (idx_q == cur_idx_q);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = wr_q;
		wr_base = rd_base_s1;
		wr_len  = rd_len_s1;
		case (cmd)
			crt_pkg::DP_APPEND: begin
				wr_en   = 1'b1;
				wr_addr = count_q;
				wr_base = lo_q[crt_pkg::ADDR_W-1:0];
				wr_len  = LW'(hi_q - lo_q);
			end
			crt_pkg::DP_KEEP: begin
				wr_en = 1'b1;
			end
			crt_pkg::DP_FINAL: begin
				wr_en   = 1'b1;
				wr_addr = cur_pos_q;
				wr_base = lo_q[crt_pkg::ADDR_W-1:0];
				wr_len  = LW'(hi_q - lo_q);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_base[wr_addr[AW-1:0]] <= wr_base;
			mem_len[wr_addr[AW-1:0]]  <= wr_len;
		end
		if (cmd == crt_pkg::DP_READ) begin
			rd_base_s1 <= mem_base[idx_q[AW-1:0]];
			rd_len_s1  <= mem_len[idx_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			crt_pkg::DP_LOAD: begin
				base_q <= in_base;
				len_q  <= in_len;
				lo_q   <= EW'(in_base);
				hi_q   <= EW'(in_base) + EW'(in_len);
			end
			crt_pkg::DP_SPAN: begin
				lo_q <= r_start;
				hi_q <= r_end;
			end
			crt_pkg::DP_GRAB, crt_pkg::DP_ABSORB: begin
				lo_q <= new_lo;
				hi_q <= new_hi;
			end
			default: begin
				lo_q <= lo_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q   <= 1'b0;
			status_q  <= 1'b0;
			hit_q     <= 1'b0;
			count_q   <= '0;
			idx_q     <= '0;
			wr_q      <= '0;
			cur_idx_q <= '0;
			cur_pos_q <= '0;
		end else begin
			case (cmd)
				crt_pkg::DP_LOAD: begin
					query_q  <= in_cmd;
					status_q <= 1'b0;
					hit_q    <= 1'b0;
					idx_q    <= '0;
				end
				crt_pkg::DP_NEXT: begin
					idx_q <= idx_q + 1'b1;
				end
				crt_pkg::DP_GRAB: begin
					cur_idx_q <= idx_q;
					idx_q     <= '0;
					wr_q      <= '0;
				end
				crt_pkg::DP_APPEND: begin
					count_q <= count_q + 1'b1;
				end
				crt_pkg::DP_FULL: begin
					status_q <= 1'b1;
				end
				crt_pkg::DP_HIT: begin
					hit_q <= 1'b1;
				end
				crt_pkg::DP_RESERVE: begin
					cur_pos_q <= wr_q;
					wr_q      <= wr_q + 1'b1;
					idx_q     <= idx_q + 1'b1;
				end
				crt_pkg::DP_ABSORB: begin
					idx_q <= idx_q + 1'b1;
				end
				crt_pkg::DP_KEEP: begin
					wr_q  <= wr_q + 1'b1;
					idx_q <= idx_q + 1'b1;
				end
				crt_pkg::DP_FINAL: begin
					count_q <= wr_q;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	assign count      = count_q;
	assign status_bit = status_q;
	assign hit_bit    = hit_q;

endmodule

// ----- rtl/core/crt_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_ctrl
// Sequencer: page rounding wait, table scan, join pass with compaction,
// write-back of the merged entry and hand-off to the output register.
// ----------------------------------------------------------------------------
module crt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_cmd,
	input  logic                out_free,
	input  crt_pkg::dp_status_t stat,
	output crt_pkg::dp_cmd_t    cmd,
	output logic                idle,
	output logic                out_load
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_JOIN_RD,
		ST_JOIN_EV,
		ST_FINAL,
		ST_RESULT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = crt_pkg::DP_NOP;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd     = crt_pkg::DP_LOAD;
					state_d = (req_cmd == crt_pkg::CMD_QUERY) ? ST_SCAN_RD : ST_DIV;
				end
			end
			ST_DIV: begin
				if (stat.div_done) begin
					cmd     = crt_pkg::DP_SPAN;
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				if (!stat.at_end) begin
					cmd     = crt_pkg::DP_READ;
					state_d = ST_SCAN_EV;
				end else begin
					state_d = ST_RESULT;
					if (!stat.is_query) begin
						cmd = stat.full ? crt_pkg::DP_FULL : crt_pkg::DP_APPEND;
					end
				end
			end
			ST_SCAN_EV: begin
				if (stat.is_query) begin
					if (stat.hit) begin
						cmd     = crt_pkg::DP_HIT;
						state_d = ST_RESULT;
					end else begin
						cmd     = crt_pkg::DP_NEXT;
						state_d = ST_SCAN_RD;
					end
				end else if (stat.touch) begin
					if (stat.covers) begin
						state_d = ST_RESULT;
					end else begin
						cmd     = crt_pkg::DP_GRAB;
						state_d = ST_JOIN_RD;
					end
				end else begin
					cmd     = crt_pkg::DP_NEXT;
					state_d = ST_SCAN_RD;
				end
			end
			ST_JOIN_RD: begin
				if (stat.at_end) begin
					state_d = ST_FINAL;
				end else if (stat.is_cur) begin
					// hold a slot for the merged entry
					cmd = crt_pkg::DP_RESERVE;
				end else begin
					cmd     = crt_pkg::DP_READ;
					state_d = ST_JOIN_EV;
				end
			end
			ST_JOIN_EV: begin
				cmd     = stat.touch ? crt_pkg::DP_ABSORB : crt_pkg::DP_KEEP;
				state_d = ST_JOIN_RD;
			end
			ST_FINAL: begin
				cmd     = crt_pkg::DP_FINAL;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign idle = (state_q == ST_IDLE);

endmodule

// ----- rtl/core/coalescing_range_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_range_table_unit
// Ordered table of page-rounded address ranges with merging insert and
// overlap query; one request at a time, one response per request.
// ----------------------------------------------------------------------------
// One request is taken at a time. A query walks the valid entries, a read
// state and an evaluate state per entry, and stops at the first hit. An insert
// first waits on the pipelined page remainder unit and the rounding step, then
// scans the same way; a merge adds a join pass over the whole table and one
// write-back. The single-port table memory with its registered read sets the
// per-entry cost. No clearing pass after reset.
module coalescing_range_table_unit #(
	parameter int MAX_RANGES = crt_pkg::MAX_RANGES_DEF,
	parameter int PAGE_BYTES = crt_pkg::PAGE_BYTES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [63:0]              s_tdata,  // base_address[31:0], length[63:32]
	input  logic                     s_tuser,  // cmd
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [crt_pkg::OUT_W-1:0] m_tdata  // status[0], hit[1], entries_used[6:2]
);

	localparam int CW = $clog2(MAX_RANGES + 1);

	crt_pkg::dp_cmd_t          cmd;
	crt_pkg::dp_status_t       stat;
	logic                      idle;
	logic                      out_load;
	logic                      out_free;
	logic [CW-1:0]             count;
	logic                      status_bit;
	logic                      hit_bit;
	logic                      out_valid_q;
	logic [crt_pkg::OUT_W-1:0] out_data_q;

	assign out_free = !out_valid_q || m_tready;

	crt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(s_tvalid),
		.req_cmd  (s_tuser),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd),
		.idle     (idle),
		.out_load (out_load)
	);

	crt_datapath #(
		.MAX_RANGES(MAX_RANGES),
		.PAGE_BYTES(PAGE_BYTES),
		.CW        (CW)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_cmd    (s_tuser),
		.in_base   (s_tdata[31:0]),
		.in_len    (s_tdata[63:32]),
		.stat      (stat),
		.count     (count),
		.status_bit(status_bit),
		.hit_bit   (hit_bit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {1'b0, crt_pkg::USED_W'(count), hit_bit, status_bit};
		end
	end

	assign s_tready = idle;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(MAX_RANGES))
		else $error("range count above table size");

	a_full_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && status_bit |-> count == CW'(MAX_RANGES))
		else $error("full reported with free entries");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !out_valid_q || m_tready)
		else $error("response overwritten");

endmodule

// ----- dv/tb_coalescing_range_table_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_coalescing_range_table_unit
// Sends insert and query requests to the range table and checks every
// response against a behavioral table kept in the bench, under varying send idling and receive stalls.
// ----------------------------------------------------------------------------
module tb_coalescing_range_table_unit;

	localparam int NRANGE = crt_pkg::MAX_RANGES_DEF;
	localparam longint PAGE = crt_pkg::PAGE_BYTES_DEF;
	localparam int STALL_LIMIT = 20000;

	typedef struct packed {
		logic        cmd;
		logic [31:0] base_address;
		logic [31:0] length;
	} req_t;

	typedef struct packed {
		logic [4:0] entries_used;
		logic       hit;
		logic       status;
	} rsp_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [crt_pkg::OUT_W-1:0] m_tdata;

	req_t   pending_reqs[$];
	rsp_t   expected_rsps[$];
	int     send_idle_pct;
	int     recv_stall_pct;
	int     errors;
	int     stall_cycles;
	int     n_insert, n_query, n_full, n_hit, n_merge;

	// table mirror
	logic [31:0] tbl_base[NRANGE];
	logic [32:0] tbl_len[NRANGE];
	int          tbl_count;

	coalescing_range_table_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	function automatic void drop_range(int idx);
		for (int k = idx; k + 1 < tbl_count; k++) begin
			tbl_base[k] = tbl_base[k + 1];
			tbl_len[k]  = tbl_len[k + 1];
		end
		if (tbl_count > 0) tbl_count--;
	endfunction

	function automatic void absorb_touching(int cur);
		int j;
		logic [33:0] rs, re, js, je, ns, ne;
		j = 0;
		while (j < tbl_count) begin
			if (j == cur) begin
				j++;
				continue;
			end
			rs = tbl_base[cur];
			re = rs + tbl_len[cur];
			js = tbl_base[j];
			je = js + tbl_len[j];
			if (js <= re && je >= rs) begin
				ns = (js < rs) ? js : rs;
				ne = (je > re) ? je : re;
				tbl_base[cur] = ns[31:0];
				tbl_len[cur]  = 33'(ne - ns);
				drop_range(j);
				n_merge++;
				if (j < cur) cur--;
			end else begin
				j++;
			end
		end
	endfunction

	function automatic logic insert_range(logic [31:0] addr, logic [31:0] len);
		logic [33:0] start, size, fin, rs, re;
		start = addr - (addr % PAGE);
		size  = ((34'(len) + PAGE - 1) / PAGE) * PAGE;
		fin   = start + size;
		for (int i = 0; i < tbl_count; i++) begin
			rs = tbl_base[i];
			re = rs + tbl_len[i];
			if (fin < rs || start > re) continue;
			if (start >= rs && fin <= re) return 1'b0;
			if (start < rs) begin
				tbl_base[i] = start[31:0];
				tbl_len[i]  = tbl_len[i] + 33'(rs - start);
				rs = start;
			end
			if (fin > rs + tbl_len[i]) tbl_len[i] = 33'(fin - rs);
			absorb_touching(i);
			return 1'b0;
		end
		if (tbl_count >= NRANGE) return 1'b1;
		tbl_base[tbl_count] = start[31:0];
		tbl_len[tbl_count]  = size[32:0];
		tbl_count++;
		return 1'b0;
	endfunction

	function automatic logic query_span(logic [31:0] addr, logic [31:0] len);
		logic [33:0] start, fin, rs, re;
		start = addr;
		fin   = start + len;
		for (int i = 0; i < tbl_count; i++) begin
			rs = tbl_base[i];
			re = rs + tbl_len[i];
			if ((start >= rs && start < re) || (fin >= rs && fin < re)) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic rsp_t predict_response(req_t r);
		rsp_t p;
		p = '0;
		if (r.cmd == crt_pkg::CMD_INSERT) begin
			p.status = insert_range(r.base_address, r.length);
			n_insert++;
			if (p.status) n_full++;
		end else begin
			p.hit = query_span(r.base_address, r.length);
			n_query++;
			if (p.hit) n_hit++;
		end
		p.entries_used = 5'(tbl_count);
		return p;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		req_t r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				r.cmd = s_tuser;
				r.base_address = s_tdata[31:0];
				r.length = s_tdata[63:32];
				expected_rsps.push_back(predict_response(r));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					r = pending_reqs.pop_front();
					s_tvalid <= 1'b1;
					s_tuser  <= r.cmd;
					s_tdata  <= {r.length, r.base_address};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor and checker
	always @(posedge clk or negedge arst_n) begin
		rsp_t got, want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[6:0];
				if (expected_rsps.size() == 0) begin
					$error("unexpected response %h", m_tdata);
					errors++;
				end else begin
					want = expected_rsps.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						errors++;
					end
					if (got.hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, got.hit);
						errors++;
					end
					if (got.entries_used !== want.entries_used) begin
						$error("entries_used: expected %0d, got %0d",
							want.entries_used, got.entries_used);
						errors++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic push_req(logic cmd, logic [31:0] addr, logic [31:0] len);
		req_t r;
		r.cmd = cmd;
		r.base_address = addr;
		r.length = len;
		pending_reqs.push_back(r);
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || s_tvalid || expected_rsps.size() > 0)
			@(posedge clk);
	endtask

	// a burst of well-formed table traffic: inserts and queries mixed at random, mostly near a cluster
	task automatic push_random_round(int n);
		logic [31:0] hub, a, l;
		hub = $urandom_range(1) ? $urandom : {4'($urandom_range(15)), 28'h0};
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: a = $urandom;
				1, 2: a = hub + $urandom_range(64) * 32'd4096;
				default: a = hub + $urandom_range(300000) * 32'd7;
			endcase
			case ($urandom_range(7))
				0: l = $urandom;
				1: l = 32'hFFFF_FFFF - $urandom_range(5000);
				2: l = 0;
				default: l = $urandom_range(20000);
			endcase
			push_req($urandom_range(99) < 55 ? crt_pkg::CMD_INSERT : crt_pkg::CMD_QUERY,
				a, l);
		end
	endtask

	initial begin
		int phase;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty-table query, extremes, zero length, merges, fill
		push_req(crt_pkg::CMD_QUERY, 32'h0, 32'h0);
		push_req(crt_pkg::CMD_INSERT, 32'h0000_1234, 32'h0);
		push_req(crt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_req(crt_pkg::CMD_QUERY, 32'hFFFF_FFFF, 32'h0);
		push_req(crt_pkg::CMD_INSERT, 32'h0001_0000, 32'h1000);
		push_req(crt_pkg::CMD_INSERT, 32'h0001_0800, 32'h10);
		push_req(crt_pkg::CMD_INSERT, 32'h0003_0000, 32'h1000);
		push_req(crt_pkg::CMD_INSERT, 32'h0000_F000, 32'h2_2000);
		push_req(crt_pkg::CMD_QUERY, 32'h0002_0000, 32'h5);
		push_req(crt_pkg::CMD_QUERY, 32'h0000_0FFF, 32'h1);
		push_req(crt_pkg::CMD_QUERY, 32'h8000_0000, 32'h7FFF_FFFF);
		for (int i = 0; i < 14; i++)
			push_req(crt_pkg::CMD_INSERT, 32'h1000_0000 + i * 32'h0010_0000, 32'h1001);
		wait_drained();

		for (phase = 0; phase < 4; phase++) begin
			send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 14 : 53) : 0;
			recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 14 : 53) : 0;
			for (int r = 0; r < 8; r++)
				push_random_round(20);
			wait_drained();
		end
		repeat (300) @(posedge clk);

		$display("Covered %0d inserts (%0d full, %0d absorbs) and %0d queries (%0d hits).",
			n_insert, n_full, n_merge, n_query, n_hit);
		if (errors == 0 && expected_rsps.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ----- files.f -----
rtl/core/crt_pkg.sv
rtl/core/crt_remdiv.sv
rtl/core/crt_datapath.sv
rtl/core/crt_ctrl.sv
rtl/core/coalescing_range_table_unit.sv
dv/tb_coalescing_range_table_unit.sv
